>>> sv/slg_pkg.sv
// ----------------------------------------------------------------------------
// slg_pkg
// Types and constants shared by the stepper pulse limit guard.
// ----------------------------------------------------------------------------
package slg_pkg;

  localparam int POSITION_BITS = 16;
  localparam int POS_OUT_W     = 16;
  localparam int TIME_W        = 64;
  localparam int DELAY_W       = 20;
  localparam int DEBOUNCE_W    = 30;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 30;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(10000000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_DELAY  = 2'd0,
    REG_MOVE_INWARD = 2'd1,
    REG_DEBOUNCE    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_LIMITED = 2'd0,
    MODE_DRIVE   = 2'd1,
    MODE_INNER   = 2'd2,
    MODE_OUTER   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [DELAY_W-1:0]    step_delay_ns;
    logic                  move_inward;
    logic [DEBOUNCE_W-1:0] debounce_ns;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ns;
    logic              inside_switch_level;
    logic              outside_switch_level;
  } tick_t;

  typedef struct packed {
    logic                 step_written;
    logic                 step_level;
    logic                 dir_level;
    logic [POS_OUT_W-1:0] position_steps;
    mode_t                mode_code;
  } result_t;

  function automatic mode_t mode_from_switches(logic in_lvl, logic out_lvl);
    mode_t m;
    if (in_lvl && out_lvl) begin
      m = MODE_DRIVE;
    end else if (in_lvl) begin
      m = MODE_OUTER;
    end else if (out_lvl) begin
      m = MODE_INNER;
    end else begin
      m = MODE_LIMITED;
    end
    return m;
  endfunction

endpackage

>>> sv/slg_if.sv
// ----------------------------------------------------------------------------
// slg_tick_if / slg_result_if
// Valid/ready channels carrying poll ticks and per-tick results.
// ----------------------------------------------------------------------------
interface slg_tick_if
  import slg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ns;
  logic              inside_switch_level;
  logic              outside_switch_level;

  modport source (output valid, now_ns, inside_switch_level, outside_switch_level,
                  input ready);
  modport sink (input valid, now_ns, inside_switch_level, outside_switch_level,
                output ready);
endinterface

interface slg_result_if
  import slg_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 step_written;
  logic                 step_level;
  logic                 dir_level;
  logic [POS_OUT_W-1:0] position_steps;
  logic [1:0]           mode_code;

  modport source (output valid, step_written, step_level, dir_level, position_steps,
                  mode_code, input ready);
  modport sink (input valid, step_written, step_level, dir_level, position_steps,
                mode_code, output ready);
endinterface

>>> sv/slg_cfg_regs.sv
// ----------------------------------------------------------------------------
// slg_cfg_regs
// Configuration register file: step delay, direction and debounce window.
// ----------------------------------------------------------------------------
module slg_cfg_regs
  import slg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_delay_ns <= '0;
      cfg.move_inward   <= 1'b1;
      cfg.debounce_ns   <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_DELAY:  cfg.step_delay_ns <= cfg_data[DELAY_W-1:0];
        REG_MOVE_INWARD: cfg.move_inward   <= cfg_data[0];
        REG_DEBOUNCE:    cfg.debounce_ns   <= cfg_data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/slg_core.sv
// ----------------------------------------------------------------------------
// slg_core
// Guard state and single-pass step logic: one tick in, one result out.
// ----------------------------------------------------------------------------
module slg_core
  import slg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  tick_t   tick,
  output result_t result
);

  mode_t                    drive_mode, drive_mode_next;
  logic                     half_phase;
  logic [POSITION_BITS-1:0] position_count, position_count_next;
  logic [TIME_W-1:0]        last_pulse_time;
  logic [TIME_W-1:0]        last_limit_time;

  logic [TIME_W-1:0]        pulse_elapsed;
  logic [TIME_W-1:0]        limit_elapsed;
  logic                     pulse_due;
  logic                     in_window;
  logic                     debounce_over;
  logic                     allow;
  logic                     do_pulse;
  logic                     set_limit;
  logic [POSITION_BITS+POS_OUT_W-1:0] pos_ext;

  assign pulse_elapsed = tick.now_ns - last_pulse_time;
  assign limit_elapsed = tick.now_ns - last_limit_time;
  assign pulse_due     = (cfg.step_delay_ns != '0) &&
                         (pulse_elapsed > TIME_W'(cfg.step_delay_ns));
  assign in_window     = limit_elapsed < TIME_W'(cfg.debounce_ns);
  assign debounce_over = pulse_elapsed > TIME_W'(cfg.debounce_ns);

  always_comb begin
    allow           = 1'b0;
    set_limit       = 1'b0;
    drive_mode_next = drive_mode;
    case (drive_mode)
      MODE_DRIVE: begin
        allow           = 1'b1;
        drive_mode_next = mode_from_switches(tick.inside_switch_level,
                                             tick.outside_switch_level);
      end
      MODE_OUTER: begin
        if (!tick.outside_switch_level) begin
          allow     = cfg.move_inward;
          set_limit = 1'b1;
        end else if (in_window) begin
          allow = cfg.move_inward;
        end else begin
          drive_mode_next = MODE_DRIVE;
        end
      end
      MODE_INNER: begin
        if (!tick.inside_switch_level) begin
          allow     = !cfg.move_inward;
          set_limit = 1'b1;
        end else if (in_window) begin
          allow = !cfg.move_inward;
        end else begin
          drive_mode_next = MODE_DRIVE;
        end
      end
      default: begin
        if (debounce_over) begin
          drive_mode_next = mode_from_switches(tick.inside_switch_level,
                                               tick.outside_switch_level);
        end
      end
    endcase
  end

  assign do_pulse = allow && pulse_due;

  always_comb begin
    position_count_next = position_count;
    if (do_pulse && half_phase) begin
      if (cfg.move_inward) begin
        position_count_next = position_count + POSITION_BITS'(1);
      end else begin
        position_count_next = position_count - POSITION_BITS'(1);
      end
    end
  end

  assign pos_ext = {{POS_OUT_W{1'b0}}, position_count_next};

  always_comb begin
    result.step_written   = do_pulse;
    result.step_level     = do_pulse & half_phase;
    result.dir_level      = cfg.move_inward;
    result.position_steps = pos_ext[POS_OUT_W-1:0];
    result.mode_code      = drive_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode      <= MODE_DRIVE;
      half_phase      <= 1'b0;
      position_count  <= '0;
      last_pulse_time <= '0;
      last_limit_time <= '0;
    end else if (fire) begin
      drive_mode     <= drive_mode_next;
      position_count <= position_count_next;
      if (do_pulse) begin
        half_phase      <= !half_phase;
        last_pulse_time <= tick.now_ns;
      end
      if (set_limit) begin
        last_limit_time <= tick.now_ns;
      end
    end
  end

endmodule

>>> sv/stepper_pulse_limit_guard.sv
// ----------------------------------------------------------------------------
// stepper_pulse_limit_guard
// Step pulse generator with limit switch guard, one result per poll tick.
//
//   channel   dir   transaction
//   tick      in    now_ns, inside_switch_level, outside_switch_level
//   result    out   step_written, step_level, dir_level, position_steps,
//                   mode_code
//   cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// One tick per clock sustained while the result is not stalled; an accepted tick
// goes to the input register, then its result to the result register, from
// which it is taken.
// The guard state updates in the same cycle the tick leaves the input register.
// Reset (rst, synchronous) empties both stages and restores state and config.
// A stalled result holds both stages; tick.ready drops only then.
// ----------------------------------------------------------------------------
module stepper_pulse_limit_guard
  import slg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  slg_tick_if.sink               tick,
  slg_result_if.source           result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  tick_t   tick_reg;
  logic    tick_valid;
  result_t res_comb;
  result_t res_reg;
  logic    res_valid;
  logic    advance;

  slg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .tick   (tick_reg),
    .result (res_comb)
  );

  assign advance    = tick_valid && (!res_valid || result.ready);
  assign tick.ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      tick_reg.now_ns               <= tick.now_ns;
      tick_reg.inside_switch_level  <= tick.inside_switch_level;
      tick_reg.outside_switch_level <= tick.outside_switch_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_comb;
    end
  end

  assign result.valid          = res_valid;
  assign result.step_written   = res_reg.step_written;
  assign result.step_level     = res_reg.step_level;
  assign result.dir_level      = res_reg.dir_level;
  assign result.position_steps = res_reg.position_steps;
  assign result.mode_code      = res_reg.mode_code;

endmodule
